>>> sv/rounded_rect_fill_blend_core_defines.svh
// Assertion macros shared by the rounded rectangle fill and blend RTL
`ifndef ROUNDED_RECT_FILL_BLEND_CORE_DEFINES_SVH
`define ROUNDED_RECT_FILL_BLEND_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define RRFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only
`define RRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rrfb_pkg.sv
// Types and constants for the rounded rectangle fill and blend pipeline
`timescale 1ns / 1ps

package rrfb_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_TOP    = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_RADIUS = 3'd4;
    localparam logic [2:0] CFG_FILL   = 3'd5;

    localparam int NUM_CH   = 3;
    localparam int QUO_BITS = 8;

    typedef logic signed [12:0] coord_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    // After position tests and first products
    typedef struct packed {
        logic                     inr;
        logic                     corner;
        logic                     r_zero;
        coord_t                   dx;
        coord_t                   dy;
        rgba_t                    dst;
        logic [15:0]              sa255;
        logic [15:0]              da_inv;
        logic [7:0]               inv;
        logic [NUM_CH-1:0][15:0]  sc_sa;
        logic [NUM_CH-1:0][15:0]  dc_da;
    } stage_a_t;

    // After squares, divisor and numerators
    typedef struct packed {
        logic                     inr;
        logic                     corner;
        logic                     r_zero;
        logic [22:0]              dx2;
        logic [22:0]              dy2;
        logic [15:0]              rr;
        logic [15:0]              dsum;
        logic [NUM_CH-1:0][23:0]  num;
        rgba_t                    dst;
    } stage_b_t;

    // Divider stage contents
    typedef struct packed {
        logic                     cov;
        logic                     dnz;
        logic [15:0]              dsum;
        logic [7:0]               alpha;
        logic [NUM_CH-1:0][23:0]  rem;
        logic [NUM_CH-1:0][7:0]   quo;
        rgba_t                    dst;
    } div_t;

endpackage

>>> sv/rounded_rect_fill_blend_core.sv
// Rounded rectangle coverage test and straight-alpha over blend, fully pipelined
//
//   channel   signals                          contents
//   ------------------------------------------------------------------------------
//   s         s_tvalid s_tready s_tdata[55:0]  pixel position and destination RGBA
//   m         m_tvalid m_tready m_tdata[39:0]  blended RGBA and coverage flag
//   cfg       cfg_wr_en cfg_addr cfg_wdata     register writes, no read-back
//
// One pixel per cycle while m_tready does not stall the output; 3 arithmetic
// stages, then one stage per quotient bit of the 8-step restoring divider.
// Each stage holds while its successor is full and stalled; bubbles close up.
// rst_n clears the stage valid bits and loads the register reset values.
`timescale 1ns / 1ps
`include "rounded_rect_fill_blend_core_defines.svh"

module rounded_rect_fill_blend_core
    import rrfb_pkg::*;
#(
    parameter int IMAGE_SIZE = 512
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pix_x[8:0], pix_y[17:9], dst_red[25:18], dst_green[33:26],
    // dst_blue[41:34], dst_alpha[49:42], zero fill
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
    // covered[32], zero fill
    output logic [39:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int NSTG = 3 + QUO_BITS;
    localparam logic [12:0] IMG_LIM = 13'(IMAGE_SIZE);

    // Configuration registers
    logic signed [10:0] left_reg, top_reg;
    logic [9:0]         width_reg, height_reg;
    logic [7:0]         radius_reg;
    logic [31:0]        fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            radius_reg <= 8'd8;
            fill_reg   <= 32'hFFFF_FFFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_LEFT:   left_reg   <= cfg_wdata[10:0];
                CFG_TOP:    top_reg    <= cfg_wdata[10:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[9:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[9:0];
                CFG_RADIUS: radius_reg <= cfg_wdata[7:0];
                CFG_FILL:   fill_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Stage valid bits and advance chain
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] go;

    always_comb
    begin
        go[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            go[k] = !vld_reg[k] || go[k+1];
    end

    assign s_tready = go[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (go[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NSTG; k++)
            begin
                if (go[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage A: position tests, corner centre offsets, first products
    logic [8:0]  px, py;
    rgba_t       dst_in;
    coord_t      pxs, pys, l13, t13, lw, th, lr, tr, lwr, thr, cx, cy;
    logic        inr, lq, rq, tq, bq, corner;
    logic [7:0]  sa, inv;
    logic [NUM_CH-1:0][7:0] sc, dc;
    stage_a_t    a_next, a_reg;

    always_comb
    begin
        px = s_tdata[8:0];
        py = s_tdata[17:9];
        dst_in.red   = s_tdata[25:18];
        dst_in.green = s_tdata[33:26];
        dst_in.blue  = s_tdata[41:34];
        dst_in.alpha = s_tdata[49:42];

        pxs = coord_t'({4'b0, px});
        pys = coord_t'({4'b0, py});
        l13 = coord_t'(left_reg);
        t13 = coord_t'(top_reg);
        lw  = l13 + coord_t'({3'b0, width_reg});
        th  = t13 + coord_t'({3'b0, height_reg});
        lr  = l13 + coord_t'({5'b0, radius_reg});
        tr  = t13 + coord_t'({5'b0, radius_reg});
        lwr = lw - coord_t'({5'b0, radius_reg});
        thr = th - coord_t'({5'b0, radius_reg});

        inr = ({4'b0, px} < IMG_LIM) && ({4'b0, py} < IMG_LIM)
            && (pxs >= l13) && (pxs < lw) && (pys >= t13) && (pys < th);

        lq = pxs < lr;
        rq = pxs >= lwr;
        tq = pys < tr;
        bq = pys >= thr;

        // First matching quadrant picks the circle centre
        corner = 1'b1;
        cx = lr;
        cy = tr;
        priority if (lq && tq)
        begin
            cx = lr;
            cy = tr;
        end
        else if (rq && tq)
        begin
            cx = lwr;
            cy = tr;
        end
        else if (lq && bq)
        begin
            cx = lr;
            cy = thr;
        end
        else if (rq && bq)
        begin
            cx = lwr;
            cy = thr;
        end
        else
            corner = 1'b0;

        sa  = fill_reg[7:0];
        inv = 8'd255 - sa;
        sc[0] = fill_reg[31:24];
        sc[1] = fill_reg[23:16];
        sc[2] = fill_reg[15:8];
        dc[0] = dst_in.red;
        dc[1] = dst_in.green;
        dc[2] = dst_in.blue;

        a_next.inr    = inr;
        a_next.corner = corner;
        a_next.r_zero = (radius_reg == 8'd0);
        a_next.dx     = pxs - cx;
        a_next.dy     = pys - cy;
        a_next.dst    = dst_in;
        a_next.sa255  = {sa, 8'd0} - {8'd0, sa};
        a_next.da_inv = dst_in.alpha * inv;
        a_next.inv    = inv;
        for (int i = 0; i < NUM_CH; i++)
        begin
            a_next.sc_sa[i] = sc[i] * sa;
            a_next.dc_da[i] = dc[i] * dst_in.alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
            a_reg <= a_next;
    end

    // Stage B: squares, combined alpha, numerators
    stage_b_t b_next, b_reg;
    logic signed [25:0] sqx, sqy;

    always_comb
    begin
        sqx = a_reg.dx * a_reg.dx;
        sqy = a_reg.dy * a_reg.dy;
        b_next.inr    = a_reg.inr;
        b_next.corner = a_reg.corner;
        b_next.r_zero = a_reg.r_zero;
        b_next.dx2    = sqx[22:0];
        b_next.dy2    = sqy[22:0];
        b_next.rr     = radius_reg * radius_reg;
        b_next.dsum   = a_reg.sa255 + a_reg.da_inv;
        b_next.dst    = a_reg.dst;
        for (int i = 0; i < NUM_CH; i++)
            b_next.num[i] = ({a_reg.sc_sa[i], 8'd0} - {8'd0, a_reg.sc_sa[i]})
                          + 24'(a_reg.dc_da[i] * a_reg.inv);
    end

    always_ff @(posedge clk)
    begin
        if (go[1])
            b_reg <= b_next;
    end

    // Stage C: circle test, alpha = D / 255, load divider
    div_t        c_next;
    logic [23:0] dist2;
    logic [16:0] alpha_tmp;

    always_comb
    begin
        dist2     = {1'b0, b_reg.dx2} + {1'b0, b_reg.dy2};
        alpha_tmp = {1'b0, b_reg.dsum} + 17'd1 + {9'd0, b_reg.dsum[15:8]};
        c_next.cov   = b_reg.inr
                     && (b_reg.r_zero || !b_reg.corner || (dist2 <= {8'd0, b_reg.rr}));
        c_next.dnz   = (b_reg.dsum != 16'd0);
        c_next.dsum  = b_reg.dsum;
        c_next.alpha = alpha_tmp[15:8];
        c_next.rem   = b_reg.num;
        c_next.quo   = '0;
        c_next.dst   = b_reg.dst;
    end

    // Divider: stage j resolves quotient bit QUO_BITS-1-j
    div_t div_reg [QUO_BITS+1];
    div_t div_next [QUO_BITS];

    assign div_reg[0] = c_next;

    always_ff @(posedge clk)
    begin
        if (go[2])
            div_reg[1] <= div_reg[0];
    end

    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        localparam int SH = QUO_BITS - 1 - j;
        logic [23:0] dsh;

        always_comb
        begin
            dsh = {8'd0, div_reg[j+1].dsum} << SH;
            div_next[j] = div_reg[j+1];
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (div_reg[j+1].rem[i] >= dsh)
                begin
                    div_next[j].rem[i]     = div_reg[j+1].rem[i] - dsh;
                    div_next[j].quo[i][SH] = 1'b1;
                end
            end
        end

        if (j < QUO_BITS - 1)
        begin : g_mid
            always_ff @(posedge clk)
            begin
                if (go[3+j])
                    div_reg[j+2] <= div_next[j];
            end
        end
    end

    div_t out_reg;

    always_ff @(posedge clk)
    begin
        if (go[NSTG-1])
            out_reg <= div_next[QUO_BITS-1];
    end

    // Blend only covered pixels with non-zero combined alpha
    logic blend;
    assign blend    = out_reg.cov && out_reg.dnz;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {7'd0, out_reg.cov,
                       blend ? out_reg.alpha  : out_reg.dst.alpha,
                       blend ? out_reg.quo[2] : out_reg.dst.blue,
                       blend ? out_reg.quo[1] : out_reg.dst.green,
                       blend ? out_reg.quo[0] : out_reg.dst.red};

    `RRFB_ASSERT_NOW(a_rem_below_divisor, m_tvalid && blend,
        (out_reg.rem[0] < {8'd0, out_reg.dsum}) && (out_reg.rem[1] < {8'd0, out_reg.dsum})
        && (out_reg.rem[2] < {8'd0, out_reg.dsum}), "divider remainder not below divisor")
    `RRFB_ASSERT_NEXT(a_no_drop, vld_reg[NSTG-2] && !go[NSTG-1],
        vld_reg[NSTG-2] && vld_reg[NSTG-1], "pipeline item lost under stall")
    `RRFB_ASSERT_NOW(a_alpha_range, m_tvalid && blend,
        out_reg.alpha >= out_reg.dsum[15:8], "blend alpha below D/256")

endmodule

>>> tb/rounded_rect_fill_blend_core_test.sv
// Self-checking testbench for the rounded rectangle fill and blend core
`timescale 1ns / 1ps

module rounded_rect_fill_blend_core_test
    import rrfb_pkg::*;
();

    localparam int PIX_LIMIT = 512;
    localparam int LATENCY   = 11;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 1050;

    typedef struct packed {
        logic       covered;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_out_t;

    typedef struct {
        logic [8:0] px;
        logic [8:0] py;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       known;
        pixel_out_t want;
    } pixel_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    int  rect_l, rect_t, rect_w, rect_h, rad;
    logic [31:0] fill;
    pixel_out_t blend_q[$];
    int  fail_count = 0;
    int  stall_cycles = 0;
    bit  calm;
    bit  sending_done;

    rounded_rect_fill_blend_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit in_disc(int px, int py, int cx, int cy, int r);
        int dx, dy;
        dx = px - cx;
        dy = py - cy;
        return dx * dx + dy * dy <= r * r;
    endfunction

    function automatic bit shape_hit(int px, int py);
        bit lq, rq, tq, bq;
        if (px >= PIX_LIMIT || py >= PIX_LIMIT)
            return 0;
        if (px < rect_l || px >= rect_l + rect_w || py < rect_t || py >= rect_t + rect_h)
            return 0;
        if (rad == 0)
            return 1;
        lq = px < rect_l + rad;
        rq = px >= rect_l + rect_w - rad;
        tq = py < rect_t + rad;
        bq = py >= rect_t + rect_h - rad;
        if (lq && tq)
            return in_disc(px, py, rect_l + rad, rect_t + rad, rad);
        if (rq && tq)
            return in_disc(px, py, rect_l + rect_w - rad, rect_t + rad, rad);
        if (lq && bq)
            return in_disc(px, py, rect_l + rad, rect_t + rect_h - rad, rad);
        if (rq && bq)
            return in_disc(px, py, rect_l + rect_w - rad, rect_t + rect_h - rad, rad);
        return 1;
    endfunction

    function automatic pixel_out_t predict_pixel(logic [8:0] px, logic [8:0] py,
        logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        pixel_out_t o;
        longint sa, inv, d;
        o = '{covered: 1'b0, alpha: a, blue: b, green: g, red: r};
        if (!shape_hit(int'(px), int'(py)))
            return o;
        o.covered = 1'b1;
        sa = fill[7:0];
        inv = 255 - sa;
        d = sa * 255 + longint'(a) * inv;
        if (d != 0)
        begin
            o.red   = 8'((longint'(fill[31:24]) * sa * 255 + longint'(r) * a * inv) / d);
            o.green = 8'((longint'(fill[23:16]) * sa * 255 + longint'(g) * a * inv) / d);
            o.blue  = 8'((longint'(fill[15:8]) * sa * 255 + longint'(b) * a * inv) / d);
            o.alpha = 8'(d / 255);
        end
        return o;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LEFT:   rect_l = int'(signed'(val[10:0]));
            CFG_TOP:    rect_t = int'(signed'(val[10:0]));
            CFG_WIDTH:  rect_w = int'(val[9:0]);
            CFG_HEIGHT: rect_h = int'(val[9:0]);
            CFG_RADIUS: rad = int'(val[7:0]);
            CFG_FILL:   fill = val;
            default: ;
        endcase
    endtask

    task automatic set_shape(int l, int t, int w, int h, int r, logic [31:0] f);
        write_reg(CFG_LEFT, 32'(l));
        write_reg(CFG_TOP, 32'(t));
        write_reg(CFG_WIDTH, 32'(w));
        write_reg(CFG_HEIGHT, 32'(h));
        write_reg(CFG_RADIUS, 32'(r));
        write_reg(CFG_FILL, f);
    endtask

    task automatic drain;
        while (blend_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    // Send one pixel; s_tvalid stays high across back-to-back transfers
    task automatic send_pixel(logic [8:0] px, logic [8:0] py, logic [7:0] r,
        logic [7:0] g, logic [7:0] b, logic [7:0] a, bit known, pixel_out_t want);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, a, b, g, r, py, px};
        blend_q.push_back(known ? want : predict_pixel(px, py, r, g, b, a));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int n, bit near);
        int px, py;
        repeat (n)
        begin
            if (near)
            begin
                px = rect_l + $urandom_range(0, rect_w + 4) - 2;
                py = rect_t + $urandom_range(0, rect_h + 4) - 2;
                if (px < 0 || px > 511)
                    px = $urandom_range(0, 511);
                if (py < 0 || py > 511)
                    py = $urandom_range(0, 511);
            end
            else
            begin
                px = $urandom_range(0, 511);
                py = $urandom_range(0, 511);
            end
            send_pixel(9'(px), 9'(py), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'b0, '0);
        end
        s_tvalid <= 1'b0;
    endtask

    // Result side: random back-pressure, check against the oldest expectation
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_cycles > 0)
        begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_cycles <= $urandom_range(0, 6);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_out_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = pixel_out_t'(m_tdata[32:0]);
            if (blend_q.size() == 0)
            begin
                $error("unexpected result %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = blend_q.pop_front();
                if (got.red !== want.red)
                begin
                    $error("out_red expected %0d actual %0d", want.red, got.red);
                    fail_count++;
                end
                if (got.green !== want.green)
                begin
                    $error("out_green expected %0d actual %0d", want.green, got.green);
                    fail_count++;
                end
                if (got.blue !== want.blue)
                begin
                    $error("out_blue expected %0d actual %0d", want.blue, got.blue);
                    fail_count++;
                end
                if (got.alpha !== want.alpha)
                begin
                    $error("out_alpha expected %0d actual %0d", want.alpha, got.alpha);
                    fail_count++;
                end
                if (got.covered !== want.covered)
                begin
                    $error("covered expected %0d actual %0d", want.covered, got.covered);
                    fail_count++;
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        int idle;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en
            || sending_done)
            idle = 0;
        else if (++idle >= WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    pixel_row_t dir_rows[$];

    task automatic add_row(int px, int py, logic [31:0] d, bit known, pixel_out_t want);
        pixel_row_t row;
        row.px = 9'(px);
        row.py = 9'(py);
        row.r = d[31:24];
        row.g = d[23:16];
        row.b = d[15:8];
        row.a = d[7:0];
        row.known = known;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic run_rows;
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].r, dir_rows[i].g,
                dir_rows[i].b, dir_rows[i].a, dir_rows[i].known, dir_rows[i].want);
        s_tvalid <= 1'b0;
        dir_rows.delete();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        calm = 0;
        sending_done = 0;
        rect_l = 0; rect_t = 0; rect_w = 0; rect_h = 0; rad = 8;
        fill = 32'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // After reset the rectangle is empty: pass-through
        add_row(0, 0, 32'h1122_3344, 1, '{1'b0, 8'h44, 8'h33, 8'h22, 8'h11});
        add_row(511, 511, 32'hFFFF_FFFF, 1, '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        run_rows();

        // Opaque fill, square corners: fill colour lands
        set_shape(10, 10, 100, 50, 0, 32'hA0B0_C0FF);
        add_row(10, 10, 32'h0000_0000, 1, '{1'b1, 8'hFF, 8'hC0, 8'hB0, 8'hA0});
        add_row(109, 59, 32'hFFFF_FFFF, 1, '{1'b1, 8'hFF, 8'hC0, 8'hB0, 8'hA0});
        add_row(110, 20, 32'h0102_0304, 1, '{1'b0, 8'h04, 8'h03, 8'h02, 8'h01});
        add_row(9, 20, 32'h0102_0304, 1, '{1'b0, 8'h04, 8'h03, 8'h02, 8'h01});
        run_rows();

        // Zero combined alpha keeps destination, still covered
        write_reg(CFG_FILL, 32'h1234_5600);
        add_row(50, 30, 32'h8899_AA00, 1, '{1'b1, 8'h00, 8'hAA, 8'h99, 8'h88});
        add_row(50, 30, 32'h8899_AA80, 0, '0);
        run_rows();

        // Rounded corners, both top quadrants and their diagonal misses
        set_shape(-5, 400, 300, 200, 20, 32'h40F0_1080);
        add_row(0, 400, 32'h1020_3040, 0, '0);
        add_row(15, 420, 32'h1020_3040, 0, '0);
        add_row(294, 401, 32'h5060_7080, 0, '0);
        add_row(280, 420, 32'h5060_7080, 0, '0);
        add_row(0, 511, 32'hFF00_FFFF, 0, '0);
        add_row(294, 511, 32'h00FF_00FF, 0, '0);
        add_row(150, 450, 32'h0000_00FF, 0, '0);
        run_rows();

        // Oversized radius, extreme registers, stray register index
        set_shape(-1024, -1024, 1023, 1023, 255, 32'hFFFF_FF7F);
        write_reg(3'd7, 32'hFFFF_FFFF);
        add_row(0, 0, 32'hFFFF_FFFF, 0, '0);
        add_row(100, 100, 32'h0000_0000, 0, '0);
        run_rows();
        set_shape(1023, 1023, 1023, 1023, 255, 32'h0);
        add_row(511, 511, 32'h1234_5678, 1, '{1'b0, 8'h78, 8'h56, 8'h34, 8'h12});
        run_rows();

        // Random phases over several shapes
        for (int ph = 0; ph < 6; ph++)
        begin
            set_shape($urandom_range(0, 400) - 60, $urandom_range(0, 400) - 60,
                $urandom_range(0, 300), $urandom_range(0, 300),
                (ph == 2) ? 0 : $urandom_range(0, (ph == 4) ? 255 : 40), $urandom);
            if (ph == 5)
                calm = 1;
            send_random(N_RANDOM / 6 * 3 / 4, 1'b1);
            send_random(N_RANDOM / 6 / 4, 1'b0);
            drain();
        end

        sending_done = 1;
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
